FILE: src/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: src/pip_pkg.sv
// constants and types of the point in polygon tester
package pip_pkg;

   localparam int COORD_BITS  = 32;
   localparam int MAX_VERTS   = 256;
   localparam int ADDR_BITS   = $clog2(MAX_VERTS);
   localparam int CNT_BITS    = $clog2(MAX_VERTS + 1);
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int OP_BITS     = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_VERTS);

   // request op codes
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TEST   = 2'd2;

   // item classes handed from front to back
   localparam logic [1:0] KIND_NOP    = 2'd0;
   localparam logic [1:0] KIND_CLEAR  = 2'd1;
   localparam logic [1:0] KIND_APPEND = 2'd2;
   localparam logic [1:0] KIND_TEST   = 2'd3;

   typedef struct packed {
      logic [1:0]                   kind;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } item_type;

   typedef struct packed {
      logic                valid;
      item_type            item;
   } queue_head_type;

   typedef struct packed {
      logic                walking;
      logic [CNT_BITS-1:0] vcount;
   } back_status_type;

endpackage

FILE: src/pip_if.sv
// request and response channel interfaces
interface pip_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [pip_pkg::OP_BITS-1:0]           op;
   logic signed [pip_pkg::COORD_BITS-1:0] coord_x;
   logic signed [pip_pkg::COORD_BITS-1:0] coord_y;

   modport source (output valid, output op, output coord_x, output coord_y, input ready);
   modport sink   (input valid, input op, input coord_x, input coord_y, output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic status;

   modport source (output valid, output inside_res, output status, input ready);
   modport sink   (input valid, input inside_res, input status, output ready);
endinterface

FILE: src/pip_front.sv
// front end: accepts requests, classifies them and queues them for the back end
module pip_front (
   input  logic                    clock,
   input  logic                    reset,
   pip_req_if.sink                 req_bus,
   output pip_pkg::queue_head_type q_head,
   input  logic                    q_pop
);
   import pip_pkg::*;

   item_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push;
   logic                 pop;
   item_type             new_item;

   assign req_bus.ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = q_pop && (count_ff != '0);

   always_comb begin
      new_item.x = req_bus.coord_x;
      new_item.y = req_bus.coord_y;
      unique case (req_bus.op)
         OP_CLEAR:  new_item.kind = KIND_CLEAR;
         OP_APPEND: new_item.kind = KIND_APPEND;
         OP_TEST:   new_item.kind = KIND_TEST;
         default:   new_item.kind = KIND_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = q_ff[rd_ptr_ff];

endmodule

FILE: src/pip_back.sv
// back end: vertex store, edge walk pipeline and response register
module pip_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pip_pkg::queue_head_type  q_head,
   output logic                     q_pop,
   pip_rsp_if.source                rsp_bus,
   output pip_pkg::back_status_type back_status
);
   import pip_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRIME = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   // vertex store
   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTS];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTS];

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] vcount_ff, vcount_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                inside_ff, inside_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_inside_ff, rsp_inside_in;
   logic                rsp_status_ff, rsp_status_in;

   logic signed [COORD_BITS-1:0] px_ff, px_in;
   logic signed [COORD_BITS-1:0] py_ff, py_in;

   // read stage
   logic                         rd_en;
   logic                         rd_prime;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic                         rd_valid_ff;
   logic                         rd_prime_ff;
   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   // difference stage
   logic                        straddle;
   logic                        up_edge;
   logic                        b_valid_ff, b_valid_in;
   logic                        b_pos_ff;
   logic signed [DIFF_BITS-1:0] a_ff, a_in;
   logic signed [DIFF_BITS-1:0] b_ff, b_in;
   logic signed [DIFF_BITS-1:0] c_ff, c_in;
   logic signed [DIFF_BITS-1:0] d_ff, d_in;

   // product stage
   logic                        c_valid_ff;
   logic                        c_pos_ff;
   logic signed [PROD_BITS-1:0] p1_ff, p1_in;
   logic signed [PROD_BITS-1:0] p2_ff, p2_in;
   logic                        left;

   logic wr_en;
   logic rsp_free;
   logic rsp_load;
   logic res_inside;
   logic res_status;
   logic pipe_empty;

   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   assign pipe_empty = !rd_valid_ff && !b_valid_ff && !c_valid_ff;

   // edge of vertex i (read data) and vertex j (previous read)
   always_comb begin
      up_edge  = (rd_y_ff <= py_ff) && (py_ff < prev_y_ff);
      straddle = up_edge || ((prev_y_ff <= py_ff) && (py_ff < rd_y_ff));
      b_valid_in = rd_valid_ff && !rd_prime_ff && straddle;
      a_in = {px_ff[COORD_BITS-1], px_ff} - {rd_x_ff[COORD_BITS-1], rd_x_ff};
      b_in = {prev_y_ff[COORD_BITS-1], prev_y_ff} - {rd_y_ff[COORD_BITS-1], rd_y_ff};
      c_in = {prev_x_ff[COORD_BITS-1], prev_x_ff} - {rd_x_ff[COORD_BITS-1], rd_x_ff};
      d_in = {py_ff[COORD_BITS-1], py_ff} - {rd_y_ff[COORD_BITS-1], rd_y_ff};
      p1_in = a_ff * b_ff;
      p2_in = c_ff * d_ff;
      // inequality flips for a downward edge
      left = c_pos_ff ? (p1_ff < p2_ff) : (p2_ff < p1_ff);
   end

   always_comb begin
      state_in   = state_ff;
      vcount_in  = vcount_ff;
      idx_in     = idx_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_prime   = 1'b0;
      rd_addr    = idx_ff[ADDR_BITS-1:0];
      rsp_load   = 1'b0;
      res_inside = 1'b0;
      res_status = 1'b0;
      inside_in  = (c_valid_ff && left) ? !inside_ff : inside_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid && rsp_free) begin
               q_pop = 1'b1;
               case (q_head.item.kind)
                  KIND_CLEAR: begin
                     vcount_in = '0;
                     rsp_load  = 1'b1;
                  end
                  KIND_APPEND: begin
                     rsp_load = 1'b1;
                     if (vcount_ff != CNT_FULL) begin
                        wr_en     = 1'b1;
                        vcount_in = vcount_ff + 1'b1;
                     end else begin
                        res_status = 1'b1;
                     end
                  end
                  KIND_TEST: begin
                     if (vcount_ff == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        px_in     = q_head.item.x;
                        py_in     = q_head.item.y;
                        inside_in = 1'b0;
                        idx_in    = '0;
                        state_in  = ST_PRIME;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_PRIME: begin
            // first edge closes the polygon: fetch the last vertex ahead of the walk
            rd_en    = 1'b1;
            rd_prime = 1'b1;
            rd_addr  = ADDR_BITS'(vcount_ff - 1'b1);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == vcount_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               rsp_load   = 1'b1;
               res_inside = inside_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_inside_in = rsp_inside_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = res_inside;
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_en;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      inside_ff     <= inside_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_status_ff <= rsp_status_in;
      rd_prime_ff   <= rd_prime;
      if (rd_valid_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      b_pos_ff <= up_edge;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      c_pos_ff <= b_pos_ff;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[vcount_ff[ADDR_BITS-1:0]] <= q_head.item.x;
         mem_y[vcount_ff[ADDR_BITS-1:0]] <= q_head.item.y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.inside_res = rsp_inside_ff;
   assign rsp_bus.status     = rsp_status_ff;

   assign back_status.walking = (state_ff != ST_IDLE);
   assign back_status.vcount  = vcount_ff;

endmodule

FILE: src/point_in_polygon_test.sv
// top level of the crossing number point in polygon tester
//
//  channel  direction  handshake            payload
//  req_bus  in         valid / ready        op, coord_x, coord_y
//  rsp_bus  out        valid / ready        inside_res, status
//
// clear, append and unused ops are answered straight from the idle state of the back end
// a point test walks the n stored vertices one edge per cycle (none are walked when n is zero),
// set by the single read port of the vertex store
// requests keep flowing into a four entry queue while the back end walks
// reset clears the vertex count and queue; the vertex store is not swept
// a stalled response holds the back end; the request side stalls once the queue is full

`include "assert_macros.svh"

module point_in_polygon_test (
   input logic       clock,
   input logic       reset,
   pip_req_if.sink   req_bus,
   pip_rsp_if.source rsp_bus
);
   import pip_pkg::*;

   queue_head_type  q_head;
   logic            q_pop;
   back_status_type back_status;

   pip_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   pip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_bus     (rsp_bus),
      .back_status (back_status)
   );

   `ASSERT_NEVER(a_inside_with_drop, rsp_bus.valid && rsp_bus.inside_res && rsp_bus.status, "inside and drop flagged together")
   `ASSERT_PROP(a_drop_only_full, rsp_bus.valid && rsp_bus.status |-> back_status.vcount == CNT_FULL, "vertex dropped while store not full")
   `ASSERT_NEVER(a_no_rsp_during_walk, back_status.walking && rsp_bus.valid, "response pending during edge walk")
   `ASSERT_PROP(a_count_range, back_status.vcount <= CNT_FULL, "vertex count beyond store depth")

endmodule

FILE: tb/pip_checker.sv
// checker that predicts and compares every response of the point in polygon tester
`timescale 1ns / 100ps

module pip_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [pip_pkg::OP_BITS-1:0]           req_op,
   input  logic signed [pip_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [pip_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_inside_res,
   input  logic                                  rsp_status,
   output int                                    fail_count,
   output int                                    pending
);
   import pip_pkg::*;

   // wide enough for the product of two coordinate differences
   localparam int WIDE = PROD_BITS + 2;

   typedef struct packed {
      logic inside_res;
      logic status;
   } pip_answer_type;

   logic signed [COORD_BITS-1:0] poly_x [MAX_VERTS];
   logic signed [COORD_BITS-1:0] poly_y [MAX_VERTS];
   logic [CNT_BITS-1:0]          vert_count;
   pip_answer_type               answer_q [$];
   int                           errors;

   // even-odd crossing count, edges from the last vertex to the first, then in order
   function automatic logic crossing_parity(input logic signed [COORD_BITS-1:0] px,
                                            input logic signed [COORD_BITS-1:0] py);
      logic parity;
      logic left;
      int cur;
      int prev;
      logic signed [COORD_BITS-1:0] xi, yi, xj, yj;
      logic signed [WIDE-1:0] run_pt, run_edge, rise_pt, rise_edge;
      parity = 1'b0;
      prev = int'(vert_count) - 1;
      for (cur = 0; cur < int'(vert_count); cur++) begin
         xi = poly_x[cur];
         yi = poly_y[cur];
         xj = poly_x[prev];
         yj = poly_y[prev];
         if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
            run_pt    = px - xi;
            run_edge  = xj - xi;
            rise_pt   = py - yi;
            rise_edge = yj - yi;
            // exact compare of the crossing, reversed for a downward edge
            if (rise_edge > 0)
               left = run_pt * rise_edge < run_edge * rise_pt;
            else
               left = run_edge * rise_pt < run_pt * rise_edge;
            parity ^= left;
         end
         prev = cur;
      end
      return parity;
   endfunction

   function automatic pip_answer_type apply_request(input logic [OP_BITS-1:0] op,
                                                    input logic signed [COORD_BITS-1:0] cx,
                                                    input logic signed [COORD_BITS-1:0] cy);
      pip_answer_type ans;
      ans = '0;
      case (op)
         OP_CLEAR: vert_count = '0;
         OP_APPEND: begin
            if (vert_count < CNT_FULL) begin
               poly_x[vert_count[ADDR_BITS-1:0]] = cx;
               poly_y[vert_count[ADDR_BITS-1:0]] = cy;
               vert_count = vert_count + 1'b1;
            end else begin
               ans.status = 1'b1;
            end
         end
         OP_TEST: ans.inside_res = crossing_parity(cx, cy);
         default: ;
      endcase
      return ans;
   endfunction

   initial begin
      vert_count = '0;
      errors     = 0;
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      pip_answer_type want;
      if (reset) begin
         answer_q.delete();
         vert_count = '0;
      end else begin
         // responses first: one accepted in this cycle never belongs to a new request
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               errors++;
               $display("%0t: response with nothing outstanding, inside_res %0b status %0b",
                        $time, rsp_inside_res, rsp_status);
            end else begin
               want = answer_q.pop_front();
               if (rsp_inside_res !== want.inside_res) begin
                  errors++;
                  $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                           $time, want.inside_res, rsp_inside_res);
               end
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %0b, actual %0b",
                           $time, want.status, rsp_status);
               end
            end
         end
         if (req_valid && req_ready)
            answer_q.push_back(apply_request(req_op, req_coord_x, req_coord_y));
      end
      pending    <= answer_q.size();
      fail_count <= errors;
   end

endmodule

FILE: tb/tb_point_in_polygon_test.sv
// testbench top of the point in polygon tester: stimulus, response pacing and verdict
`timescale 1ns / 100ps

module tb_point_in_polygon_test;
   import pip_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1050;
   localparam int LONG_HOLD   = 300;
   localparam logic signed [COORD_BITS-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_BITS-1:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_BITS-1:0] ONE   = 32'sh0001_0000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   sent;
   bit   tx_burst;

   // vertices as the block should hold them, used to aim probes at ties
   logic signed [COORD_BITS-1:0] outline_x [$];
   logic signed [COORD_BITS-1:0] outline_y [$];

   pip_req_if req_bus ();
   pip_rsp_if rsp_bus ();

   point_in_polygon_test dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pip_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_op         (req_bus.op),
      .req_coord_x    (req_bus.coord_x),
      .req_coord_y    (req_bus.coord_y),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_inside_res (rsp_bus.inside_res),
      .rsp_status     (rsp_bus.status),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send(input logic [OP_BITS-1:0] op,
                       input logic signed [COORD_BITS-1:0] cx,
                       input logic signed [COORD_BITS-1:0] cy);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.coord_x <= cx;
      req_bus.coord_y <= cy;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
      if (op == OP_CLEAR) begin
         outline_x.delete();
         outline_y.delete();
      end else if (op == OP_APPEND && outline_x.size() < MAX_VERTS) begin
         outline_x.push_back(cx);
         outline_y.push_back(cy);
      end
   endtask

   // hold the sender until every response is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic signed [COORD_BITS-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0: return C_MIN;
         1: return C_MAX;
         2: return '0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // span 0 means the whole coordinate range
   function automatic logic signed [COORD_BITS-1:0] span_coord(input int unsigned span);
      longint v;
      if (span == 0)
         return $urandom;
      v = longint'($urandom_range(0, 2 * span)) - longint'(span);
      return COORD_BITS'(v);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] vertex_coord(
         input int unsigned span, input logic signed [COORD_BITS-1:0] last);
      case ($urandom_range(0, 9))
         0: return last;   // axis-parallel edges
         1: return extreme_coord();
         default: return span_coord(span);
      endcase
   endfunction

   function automatic logic signed [COORD_BITS-1:0] probe_coord(input int unsigned span,
                                                              input bit on_y);
      int sel;
      int idx;
      sel = $urandom_range(0, 9);
      if (sel < 3 && outline_x.size() > 0) begin
         idx = $urandom_range(0, outline_x.size() - 1);
         return on_y ? outline_y[idx] : outline_x[idx];
      end
      if (sel == 3)
         return extreme_coord();
      return span_coord(span);
   endfunction

   // stimulus
   initial begin
      int unsigned spans [4];
      int unsigned span;
      int pick;
      int nv;
      int k;
      logic signed [COORD_BITS-1:0] cx, cy;
      spans = '{0, 16, 1 << 20, 1 << 30};
      sent = 0;
      tx_burst = 1'b0;
      reset <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.op      <= OP_CLEAR;
      req_bus.coord_x <= '0;
      req_bus.coord_y <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty and tiny polygons, full-range square, small triangle
      send(OP_TEST, '0, '0);
      send(OP_UNUSED, C_MAX, C_MIN);
      send(OP_APPEND, C_MIN, C_MIN);
      send(OP_TEST, C_MIN, C_MIN);
      send(OP_APPEND, C_MAX, C_MIN);
      send(OP_TEST, '0, '0);
      send(OP_APPEND, C_MAX, C_MAX);
      send(OP_APPEND, C_MIN, C_MAX);
      send(OP_TEST, '0, '0);
      send(OP_TEST, C_MIN, '0);
      send(OP_TEST, C_MAX, '0);
      send(OP_TEST, '0, C_MIN);
      send(OP_TEST, '0, C_MAX);
      send(OP_TEST, C_MIN, C_MAX - 1);
      send(OP_UNUSED, '0, '0);
      send(OP_CLEAR, C_MAX, C_MIN);
      send(OP_TEST, '0, '0);
      send(OP_APPEND, '0, '0);
      send(OP_APPEND, 16 * ONE, '0);
      send(OP_APPEND, '0, 16 * ONE);
      send(OP_TEST, ONE, ONE);
      send(OP_TEST, -ONE, ONE);
      send(OP_TEST, 8 * ONE, 8 * ONE);
      send(OP_TEST, 8 * ONE - 1, 8 * ONE);
      drain();

      // fill the store, overflow it, then walk the longest polygon
      send(OP_CLEAR, '0, '0);
      for (k = 0; k < MAX_VERTS; k++)
         send(OP_APPEND, span_coord(1 << 20), span_coord(1 << 20));
      send(OP_APPEND, C_MAX, C_MIN);
      repeat (4) send(OP_TEST, probe_coord(1 << 20, 1'b0), probe_coord(1 << 20, 1'b1));
      send(OP_APPEND, '0, '0);
      send(OP_CLEAR, '0, '0);

      // random polygons with probes, some noise and broken sequences
      while (sent < ITEM_TARGET) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         span = spans[$urandom_range(0, 3)];
         if (pick < 3) begin
            drain();
         end else if (pick < 10) begin
            send(OP_BITS'($urandom_range(0, 3)), $urandom, $urandom);
         end else begin
            // now and then keep the old polygon and grow it
            if (pick >= 18)
               send(OP_CLEAR, $urandom, $urandom);
            case ($urandom_range(0, 19))
               0, 1: nv = $urandom_range(0, 2);
               2: nv = $urandom_range(20, 60);
               default: nv = $urandom_range(3, 10);
            endcase
            cx = span_coord(span);
            cy = span_coord(span);
            repeat (nv) begin
               cx = vertex_coord(span, cx);
               cy = vertex_coord(span, cy);
               send(OP_APPEND, cx, cy);
            end
            repeat ($urandom_range(2, 10))
               send(OP_TEST, probe_coord(span, 1'b0), probe_coord(span, 1'b1));
            if ($urandom_range(0, 7) == 0)
               send(OP_UNUSED, $urandom, $urandom);
         end
      end

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // response pacing
   initial begin
      int stall;
      int received;
      bit rx_burst;
      received = 0;
      rx_burst = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (received % 48 == 0)
            rx_burst = ($urandom_range(0, 2) == 0);
         // long hold lets the request queue fill and back up the sender
         if (received == 30 || received == 520)
            stall = LONG_HOLD;
         else
            stall = rx_burst ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         received++;
      end
   end

   initial begin
      #30_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
